### src/matrix_inverse_3x3_assert.svh
// ----------------------------------------------------------------------------
// matrix_inverse_3x3 assertion macros
// shared concurrent assertion forms, clocked on i_clk and held off in reset
// ----------------------------------------------------------------------------
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH

// same-cycle implication
`define MI3_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define MI3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/mi3_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_pkg
// types, constants and helpers shared by the 3x3 matrix inverse
// ----------------------------------------------------------------------------
package mi3_pkg;

    // quotient bits produced by the divider, bit 32 down to bit 0
    localparam int C_QBITS = 33;

    // element indexes (row*3+col) of a, b, c, d for each cofactor a*b - c*d
    localparam logic [3:0] C_COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    // one classified matrix waiting for division
    typedef struct packed {
        logic [8:0][63:0] amag;
        logic [8:0]       aneg;
        logic [97:0]      dmag;
        logic             dneg;
        logic             sing;
    } t_qitem;

    // sign and magnitude to a saturated signed 32-bit value
    function automatic logic [31:0] f_sat(input logic big, input logic [65:0] mag,
                                          input logic neg);
        logic [31:0] res;
        if (neg) begin
            if (big || mag > 66'h0_8000_0000) res = 32'h8000_0000;
            else res = 32'h0 - mag[31:0];
        end else begin
            if (big || mag > 66'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
            else res = mag[31:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

### src/mi3_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// mi3_front
// cofactors, exact determinant and sign/magnitude split, six stages
// ----------------------------------------------------------------------------
module mi3_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [287:0]    i_data,
    output logic            o_push,
    output mi3_pkg::t_qitem o_item,
    input  logic            i_full
);
    import mi3_pkg::*;

    logic [5:0]         r_vld;
    logic               w_en;
    logic signed [31:0] w_m [9];
    logic signed [63:0] r_prod [18];
    logic signed [31:0] r_e1 [3];
    logic signed [31:0] r_e2 [3];
    logic signed [63:0] r_cof2 [9];
    logic signed [63:0] r_cof3 [9];
    logic signed [63:0] r_cof4 [9];
    logic signed [63:0] r_cof5 [9];
    logic signed [63:0] r_phi [3];
    logic signed [64:0] r_plo [3];
    logic signed [97:0] r_term [3];
    logic signed [97:0] r_det;
    t_qitem             r_item;

    assign w_en    = !r_vld[5] || !i_full;
    assign o_ready = w_en;
    assign o_push  = r_vld[5] && !i_full;
    assign o_item  = r_item;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            w_m[k] = $signed(i_data[32*k +: 32]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[2*k]   <= w_m[C_COF_IDX[k][0]] * w_m[C_COF_IDX[k][1]];
                r_prod[2*k+1] <= w_m[C_COF_IDX[k][2]] * w_m[C_COF_IDX[k][3]];
                r_cof2[k]     <= r_prod[2*k] - r_prod[2*k+1];
                r_cof3[k]     <= r_cof2[k];
                r_cof4[k]     <= r_cof3[k];
                r_cof5[k]     <= r_cof4[k];
            end
            for (int j = 0; j < 3; j++) begin
                r_e1[j]   <= w_m[j];
                r_e2[j]   <= r_e1[j];
                // row 0 element times cofactor in two 32-bit halves
                r_phi[j]  <= r_e2[j] * $signed(r_cof2[3*j][63:32]);
                r_plo[j]  <= r_e2[j] * $signed({1'b0, r_cof2[3*j][31:0]});
                r_term[j] <= $signed({{2{r_phi[j][63]}}, r_phi[j], 32'h0})
                           + $signed({{33{r_plo[j][64]}}, r_plo[j]});
            end
            r_det <= r_term[0] + r_term[1] + r_term[2];

            for (int k = 0; k < 9; k++) begin
                r_item.aneg[k] <= r_cof5[k][63];
                r_item.amag[k] <= r_cof5[k][63] ? 64'h0 - r_cof5[k] : r_cof5[k];
            end
            r_item.dneg <= r_det[97];
            r_item.dmag <= r_det[97] ? 98'h0 - r_det : r_det;
            r_item.sing <= (r_det == '0);
        end
    end

endmodule
`default_nettype wire

### src/mi3_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"
// ----------------------------------------------------------------------------
// mi3_queue
// short fifo between the classifying front and the divider back
// ----------------------------------------------------------------------------
module mi3_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  mi3_pkg::t_qitem i_data,
    output logic            o_full,
    input  logic            i_pop,
    output mi3_pkg::t_qitem o_data,
    output logic            o_empty
);
    import mi3_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qitem          r_mem [DEPTH];
    logic [AW-1:0]   r_wr;
    logic [AW-1:0]   r_rd;
    logic [CW-1:0]   r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    `MI3_ASSERT(a_no_overflow, i_push, !o_full, "queue written while full")
    `MI3_ASSERT(a_no_underflow, i_pop, !o_empty, "queue read while empty")
    `MI3_ASSERT_NEXT(a_cnt_up, i_push && !i_pop, r_cnt == CW'($past(r_cnt) + 1'b1), "fill count lost a write")

endmodule
`default_nettype wire

### src/mi3_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "matrix_inverse_3x3_assert.svh"
// ----------------------------------------------------------------------------
// mi3_back
// nine-lane pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module mi3_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  mi3_pkg::t_qitem i_item,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_tvalid,
    input  logic            i_tready,
    output logic [319:0]    o_tdata,
    output logic            o_tuser
);
    import mi3_pkg::*;

    localparam int NS = C_QBITS + 1;

    logic [NS-1:0] r_vld;
    logic          w_en;
    logic [97:0]   r_dmag [NS];
    logic          r_sing [NS];
    logic [31:0]   r_detv [NS];
    logic [95:0]   r_rem [NS][9];
    logic [32:0]   r_q [NS][9];
    logic          r_ovf [NS][9];
    logic          r_neg [NS][9];
    logic [130:0]  w_dsh [NS];
    logic          w_ge [NS][9];
    logic          r_ov;
    logic [319:0]  r_data;
    logic          r_user;

    assign w_en     = !r_ov || i_tready;
    assign o_pop    = w_en && !i_empty;
    assign o_tvalid = r_ov;
    assign o_tdata  = r_data;
    assign o_tuser  = r_user;

    // divisor aligned to the quotient bit of each stage
    always_comb begin
        w_dsh[0] = '0;
        for (int l = 0; l < 9; l++) w_ge[0][l] = 1'b0;
        for (int s = 1; s < NS; s++) begin
            w_dsh[s] = {33'h0, r_dmag[s-1]} << (NS - 1 - s);
            for (int l = 0; l < 9; l++) begin
                w_ge[s][l] = ({35'h0, r_rem[s-1][l]} >= w_dsh[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_ov  <= 1'b0;
        end else if (w_en) begin
            r_vld <= {r_vld[NS-2:0], o_pop};
            r_ov  <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dmag[0] <= i_item.dmag;
            r_sing[0] <= i_item.sing;
            r_detv[0] <= f_sat(1'b0, i_item.dmag[97:32], i_item.dneg);
            for (int l = 0; l < 9; l++) begin
                r_rem[0][l] <= {i_item.amag[l], 32'h0};
                r_q[0][l]   <= '0;
                r_ovf[0][l] <= ({35'h0, i_item.amag[l], 32'h0} >= {i_item.dmag, 33'h0});
                r_neg[0][l] <= i_item.aneg[l] ^ i_item.dneg;
            end
            for (int s = 1; s < NS; s++) begin
                r_dmag[s] <= r_dmag[s-1];
                r_sing[s] <= r_sing[s-1];
                r_detv[s] <= r_detv[s-1];
                for (int l = 0; l < 9; l++) begin
                    r_ovf[s][l] <= r_ovf[s-1][l];
                    r_neg[s][l] <= r_neg[s-1][l];
                    if (w_ge[s][l]) begin
                        r_rem[s][l] <= r_rem[s-1][l] - w_dsh[s][95:0];
                        r_q[s][l]   <= r_q[s-1][l] | (33'h1 << (NS - 1 - s));
                    end else begin
                        r_rem[s][l] <= r_rem[s-1][l];
                        r_q[s][l]   <= r_q[s-1][l];
                    end
                end
            end
            r_user <= r_sing[NS-1];
            for (int l = 0; l < 9; l++) begin
                r_data[32*l +: 32] <= r_sing[NS-1] ? 32'h0 :
                    f_sat(r_ovf[NS-1][l], {33'h0, r_q[NS-1][l]}, r_neg[NS-1][l]);
            end
            r_data[319:288] <= r_sing[NS-1] ? 32'h0 : r_detv[NS-1];
        end
    end

    `MI3_ASSERT(a_sing_zero, o_tvalid && o_tuser, o_tdata == '0, "singular result not zero")
    `MI3_ASSERT(a_sing_det, r_vld[0] && r_sing[0], r_dmag[0] == '0, "singular with nonzero det")
    `MI3_ASSERT_NEXT(a_refill, o_tvalid && i_tready && r_vld[NS-1], o_tvalid, "finished result dropped")

endmodule
`default_nettype wire

### src/matrix_inverse_3x3.sv
`timescale 1ns / 1ps
`default_nettype none
// 3x3 matrix inverse by the adjugate, Q16.16 in and out.
// The slave channel takes one matrix per transaction, nine signed 32-bit
// elements row by row with row 0 column 0 in the lowest bits of tdata.
// The master channel returns one result per matrix, in order: the nine
// inverse elements row by row, then the determinant, all saturated Q16.16;
// tuser is the singular flag, and with it set every data field is zero.
// Throughput is one matrix per clock while the receiver is ready. From the
// slave transaction a matrix passes six front stages (products, cofactors,
// determinant partial products, terms, sum, sign split), the queue and the
// back end, where the restoring divider gives the 33 quotient bits one bit
// per stage in each of nine lanes.
// When the receiver stalls, the output register and the divider hold, the
// queue fills, then the front stalls and tready falls.
// Reset clears all valid bits and the queue; no result is pending after it.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// top level: front, queue and divider back end
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // row0_col0, row0_col1, row0_col2, row1_col0 .. row2_col2
    input  logic [287:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // inv_r0_c0 .. inv_r2_c2, det_value
    output logic [319:0] o_m_axis_tdata,
    // singular
    output logic [0:0]   o_m_axis_tuser
);
    import mi3_pkg::*;

    t_qitem w_fitem;
    t_qitem w_bitem;
    logic   w_push;
    logic   w_full;
    logic   w_pop;
    logic   w_empty;
    logic   w_sing;

    mi3_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_data  (i_s_axis_tdata),
        .o_push  (w_push),
        .o_item  (w_fitem),
        .i_full  (w_full)
    );

    mi3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_fitem),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_data  (w_bitem),
        .o_empty (w_empty)
    );

    mi3_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_bitem),
        .i_empty  (w_empty),
        .o_pop    (w_pop),
        .o_tvalid (o_m_axis_tvalid),
        .i_tready (i_m_axis_tready),
        .o_tdata  (o_m_axis_tdata),
        .o_tuser  (w_sing)
    );

    assign o_m_axis_tuser[0] = w_sing;

endmodule
`default_nettype wire

### dv/tb_matrix_inverse_3x3.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_matrix_inverse_3x3
// streams matrices through the 3x3 inverse and checks each inverse,
// determinant and singular flag against an exact wide-integer calculation
// ----------------------------------------------------------------------------

typedef struct {
    logic [31:0] inv [9];
    logic [31:0] det;
    logic        sing;
} t_inv_result;

class inverse_scoreboard;
    t_inv_result pending[$];
    int          errors = 0;

    // saturate a signed wide quotient to 32 bits
    static function logic [31:0] clamp32(logic signed [199:0] v);
        if (v > 200'sd2147483647) return 32'h7FFF_FFFF;
        if (v < -200'sd2147483648) return 32'h8000_0000;
        return v[31:0];
    endfunction

    function void note_matrix(logic [287:0] data);
        logic signed [199:0] m [9];
        logic signed [199:0] adj [9];
        logic signed [199:0] det, num;
        t_inv_result         res;
        for (int i = 0; i < 9; i++) m[i] = $signed(data[i*32 +: 32]);
        adj[0] = m[4]*m[8] - m[5]*m[7];
        adj[1] = m[2]*m[7] - m[1]*m[8];
        adj[2] = m[1]*m[5] - m[2]*m[4];
        adj[3] = m[5]*m[6] - m[3]*m[8];
        adj[4] = m[0]*m[8] - m[2]*m[6];
        adj[5] = m[2]*m[3] - m[0]*m[5];
        adj[6] = m[3]*m[7] - m[4]*m[6];
        adj[7] = m[1]*m[6] - m[0]*m[7];
        adj[8] = m[0]*m[4] - m[1]*m[3];
        det = m[0]*adj[0] + m[1]*adj[3] + m[2]*adj[6];
        res.sing = (det == 0);
        if (res.sing) begin
            foreach (res.inv[i]) res.inv[i] = '0;
            res.det = '0;
        end else begin
            // signed division truncates toward zero
            for (int i = 0; i < 9; i++) begin
                num = adj[i] <<< 32;
                res.inv[i] = clamp32(num / det);
            end
            res.det = clamp32(det / (200'sd1 <<< 32));
        end
        pending.push_back(res);
    endfunction

    function void check_result(logic [319:0] data, logic sing);
        t_inv_result exp_res;
        if (pending.size() == 0) begin
            $error("result with no matrix outstanding");
            errors++;
            return;
        end
        exp_res = pending.pop_front();
        for (int i = 0; i < 9; i++)
            if (data[i*32 +: 32] !== exp_res.inv[i]) begin
                $error("inv_r%0d_c%0d expected %h actual %h", i / 3, i % 3,
                       exp_res.inv[i], data[i*32 +: 32]);
                errors++;
            end
        if (data[288 +: 32] !== exp_res.det) begin
            $error("det_value expected %h actual %h", exp_res.det, data[288 +: 32]);
            errors++;
        end
        if (sing !== exp_res.sing) begin
            $error("singular expected %b actual %b", exp_res.sing, sing);
            errors++;
        end
    endfunction
endclass

module tb_matrix_inverse_3x3;
    localparam int N_RANDOM = 1820;
    localparam int LIMIT    = 400000;

    logic         i_clk = 0;
    logic         i_rst_n = 0;
    logic         s_valid = 0;
    logic         s_ready;
    logic [287:0] s_data = '0;
    logic         m_valid;
    logic         m_ready = 0;
    logic [319:0] m_data;
    logic [0:0]   m_user;

    inverse_scoreboard sb = new();
    bit   calm = 0;       // no idling in the last part
    bit   hold_off = 0;   // long receiver stall
    bit   src_done = 0;
    int   cycles = 0;

    matrix_inverse_3x3 u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tuser  (m_user)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT) begin
            $display("matrix_inverse_3x3 verification failed");
            $finish;
        end
        if (i_rst_n && s_valid && s_ready) sb.note_matrix(s_data);
        if (i_rst_n && m_valid && m_ready) sb.check_result(m_data, m_user[0]);
    end

    // receiver: random stall bursts, plus one long hold-off
    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_off) m_ready <= 0;
            else if (!calm && $urandom_range(0, 5) == 0) begin
                gap = $urandom_range(1, 19);
                m_ready <= 0;
                repeat (gap) @(negedge i_clk);
                m_ready <= 1;
            end else m_ready <= 1;
        end
    end

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'h0001_0000;
            4: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFF;
            // modest values keep most inverses in range
            5, 6: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_matrix(logic [31:0] e [9]);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 19);
            s_valid <= 0;
            repeat (gap) @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) s_data[i*32 +: 32] <= e[i];
        s_valid <= 1;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
    endtask

    task automatic send_scaled(int diag, int off);
        logic [31:0] e [9];
        for (int i = 0; i < 9; i++) e[i] = (i % 4 == 0) ? diag : off;
        send_matrix(e);
    endtask

    initial begin
        logic [31:0] e [9];
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1;
        // directed: identity, scaled, singular, extremes, tiny determinant
        send_scaled(32'h0001_0000, 0);
        send_scaled(32'h0002_0000, 0);
        send_scaled(-32'sh0001_0000, 0);
        send_scaled(0, 0);
        send_scaled(32'h0001_0000, 32'h0001_0000);   // rank one
        send_scaled(32'h7FFF_FFFF, 0);
        send_scaled(32'h8000_0000, 0);
        send_scaled(1, 0);                          // determinant below one lsb
        send_scaled(32'h0000_0100, 0);
        send_scaled(32'h8000_0000, 32'h7FFF_FFFF);
        send_scaled(32'h7FFF_FFFF, 32'h8000_0000);
        send_scaled(32'hFFFF_FFFF, 1);
        send_scaled(32'h0001_0000, 32'h0000_8000);
        for (int i = 0; i < 9; i++) e[i] = 32'hFFFF_FFFF;
        send_matrix(e);
        for (int i = 0; i < 9; i++) e[i] = 32'hAAAA_5555 ^ (32'h1 << (i * 3));
        send_matrix(e);
        for (int i = 0; i < 9; i++) e[i] = {i[3:0], 28'h0} | 32'h0001_0000;
        send_matrix(e);
        // long receiver hold-off while the sender keeps offering
        // enough transactions to fill the pipeline and the queue
        fork
            begin
                hold_off = 1;
                repeat (200) @(negedge i_clk);
                hold_off = 0;
            end
            for (int k = 0; k < 80; k++) begin
                for (int i = 0; i < 9; i++) e[i] = $urandom;
                send_matrix(e);
            end
        join
        for (int n = 0; n < N_RANDOM; n++) begin
            if (n == N_RANDOM - 300) calm = 1;
            for (int i = 0; i < 9; i++) e[i] = rand_elem();
            // copy a row now and then to force a singular matrix
            if ($urandom_range(0, 9) == 0) begin
                e[6] = e[0];
                e[7] = e[1];
                e[8] = e[2];
            end
            send_matrix(e);
        end
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("matrix_inverse_3x3 verification clean");
        else
            $display("matrix_inverse_3x3 verification failed");
        $finish;
    end
endmodule

### matrix_inverse_3x3.f
+incdir+src
src/mi3_pkg.sv
src/mi3_front.sv
src/mi3_queue.sv
src/mi3_back.sv
src/matrix_inverse_3x3.sv
dv/tb_matrix_inverse_3x3.sv
